// ===== rtl/core/pss_pkg.sv =====
// shared types and codes for the positional sequence store
package pss_pkg;

  // request codes
  localparam logic [3:0] REQ_INS_FIRST = 4'd0;
  localparam logic [3:0] REQ_INS_LAST  = 4'd1;
  localparam logic [3:0] REQ_INS_AT    = 4'd2;
  localparam logic [3:0] REQ_DEL_FIRST = 4'd3;
  localparam logic [3:0] REQ_DEL_LAST  = 4'd4;
  localparam logic [3:0] REQ_DEL_AT    = 4'd5;
  localparam logic [3:0] REQ_FIND_FIRST = 4'd6;
  localparam logic [3:0] REQ_FIND_LAST = 4'd7;
  localparam logic [3:0] REQ_COUNT_KEY = 4'd8;
  localparam logic [3:0] REQ_REVERSE   = 4'd9;

  // status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_EMPTY     = 3'd1;
  localparam logic [2:0] ST_BAD_POS   = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_NOT_FOUND = 3'd4;

  // request word
  typedef struct packed {
    logic [3:0]         req_type;
    logic signed [31:0] value;
    logic [6:0]         position;
  } req_word_t;

  // response word
  typedef struct packed {
    logic [2:0]         status;
    logic signed [31:0] removed_value;
    logic [6:0]         found_position;
    logic [6:0]         match_count;
    logic [6:0]         entry_count;
  } rsp_word_t;

endpackage

// ===== rtl/core/pss_ram.sv =====
// generic single write port ram with registered read
module pss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/pss_ctrl.sv =====
// request sequencer: walks the entry ram for shifts, searches and reversal
module pss_ctrl #(
  parameter int DEPTH = 64,
  parameter int DATA_WIDTH = 32,
  localparam int AW = $clog2(DEPTH),
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  pss_pkg::req_word_t    in_data,
  input  logic                  res_free,
  output logic                  res_valid,
  output pss_pkg::rsp_word_t    res_data,
  output logic                  mem_we,
  output logic [AW-1:0]         mem_waddr,
  output logic [DATA_WIDTH-1:0] mem_wdata,
  output logic [AW-1:0]         mem_raddr,
  input  logic [DATA_WIDTH-1:0] mem_rdata
);

  localparam int PW = ((CW > 7) ? CW : 7) + 1;

  typedef enum logic [3:0] {
    S_IDLE, S_INS_SHIFT, S_INS_PUT, S_DEL_RD, S_DEL_GET, S_DEL_SHIFT,
    S_SRCH, S_REV_LO, S_REV_HI, S_REV_A, S_REV_B, S_REV_C, S_DONE
  } state_t;

  state_t                  state;
  logic [CW-1:0]           cnt;
  logic [CW-1:0]           ptr;
  logic [CW-1:0]           lim;
  logic [3:0]              req;
  logic [DATA_WIDTH-1:0]   key;
  logic [2:0]              status;
  logic [31:0]             removed;
  logic [CW-1:0]           hits;
  logic [CW-1:0]           where;
  logic                    pend;
  logic [AW-1:0]           pend_addr;
  logic                    chk;
  logic [CW-1:0]           chk_idx;
  logic [DATA_WIDTH-1:0]   tmp;

  logic                    accept;
  logic [PW-1:0]           pos_x;
  logic [PW-1:0]           cnt_x;
  logic [DATA_WIDTH-1:0]   in_key;
  logic                    put_we;
  logic [AW-1:0]           put_addr;
  logic [DATA_WIDTH-1:0]   put_data;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && (state == S_IDLE);
  assign pos_x    = PW'(in_data.position);
  assign cnt_x    = PW'(cnt);
  assign in_key   = DATA_WIDTH'($unsigned(in_data.value));

  // direct writes issued by the sequencer itself
  always_comb begin
    put_we   = 1'b0;
    put_addr = '0;
    put_data = key;
    unique case (state)
      S_INS_PUT: begin
        put_we   = 1'b1;
        put_addr = AW'(lim);
        put_data = key;
      end
      S_REV_B: begin
        put_we   = 1'b1;
        put_addr = AW'(ptr);
        put_data = mem_rdata;
      end
      S_REV_C: begin
        put_we   = 1'b1;
        put_addr = AW'(lim);
        put_data = tmp;
      end
      default: begin
        put_we = 1'b0;
      end
    endcase
  end

  // a pending shift write lands the word read in the previous cycle
  assign mem_we    = pend | put_we;
  assign mem_waddr = pend ? pend_addr : put_addr;
  assign mem_wdata = pend ? mem_rdata : put_data;

  // read address per state
  always_comb begin
    unique case (state)
      S_INS_SHIFT: mem_raddr = AW'(ptr - CW'(1));
      S_DEL_RD:    mem_raddr = AW'(ptr);
      S_DEL_SHIFT: mem_raddr = AW'(ptr + CW'(1));
      S_SRCH:      mem_raddr = AW'(ptr);
      S_REV_LO:    mem_raddr = AW'(ptr);
      S_REV_HI:    mem_raddr = AW'(lim);
      S_REV_A:     mem_raddr = AW'(lim);
      default:     mem_raddr = '0;
    endcase
  end

  // response word
  assign res_valid = (state == S_DONE) && res_free;
  always_comb begin
    res_data.status        = status;
    res_data.removed_value = removed;
    res_data.found_position =
      (req == pss_pkg::REQ_FIND_FIRST || req == pss_pkg::REQ_FIND_LAST) ? 7'(where) : 7'd0;
    res_data.match_count   = (req == pss_pkg::REQ_COUNT_KEY) ? 7'(hits) : 7'd0;
    res_data.entry_count   = 7'(cnt);
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      pend  <= 1'b0;
      chk   <= 1'b0;
    end else begin
      pend <= 1'b0;
      chk  <= 1'b0;
      // compare the word read in the previous cycle
      if (chk && (mem_rdata == key)) begin
        hits <= hits + CW'(1);
        if (req == pss_pkg::REQ_FIND_LAST || where == '0) begin
          where <= chk_idx + CW'(1);
        end
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            req     <= in_data.req_type;
            key     <= in_key;
            status  <= pss_pkg::ST_OK;
            removed <= '0;
            hits    <= '0;
            where   <= '0;
            state   <= S_DONE;
            case (in_data.req_type) inside
              pss_pkg::REQ_INS_FIRST, pss_pkg::REQ_INS_LAST, pss_pkg::REQ_INS_AT: begin
                if (in_data.req_type == pss_pkg::REQ_INS_AT &&
                    (pos_x == '0 || pos_x > cnt_x + PW'(1))) begin
                  status <= pss_pkg::ST_BAD_POS;
                end else if (cnt == CW'(DEPTH)) begin
                  status <= pss_pkg::ST_FULL;
                end else begin
                  ptr   <= cnt;
                  state <= S_INS_SHIFT;
                  if (in_data.req_type == pss_pkg::REQ_INS_FIRST) begin
                    lim <= '0;
                  end else if (in_data.req_type == pss_pkg::REQ_INS_LAST) begin
                    lim <= cnt;
                  end else begin
                    lim <= CW'(pos_x - PW'(1));
                  end
                end
              end
              pss_pkg::REQ_DEL_FIRST, pss_pkg::REQ_DEL_LAST, pss_pkg::REQ_DEL_AT: begin
                if (cnt == '0) begin
                  status <= pss_pkg::ST_EMPTY;
                end else if (in_data.req_type == pss_pkg::REQ_DEL_AT &&
                             (pos_x == '0 || pos_x > cnt_x)) begin
                  status <= pss_pkg::ST_BAD_POS;
                end else begin
                  state <= S_DEL_RD;
                  if (in_data.req_type == pss_pkg::REQ_DEL_FIRST) begin
                    ptr <= '0;
                  end else if (in_data.req_type == pss_pkg::REQ_DEL_LAST) begin
                    ptr <= cnt - CW'(1);
                  end else begin
                    ptr <= CW'(pos_x - PW'(1));
                  end
                end
              end
              pss_pkg::REQ_FIND_FIRST, pss_pkg::REQ_FIND_LAST, pss_pkg::REQ_COUNT_KEY: begin
                if (cnt == '0) begin
                  status <= pss_pkg::ST_EMPTY;
                end else begin
                  ptr   <= '0;
                  state <= S_SRCH;
                end
              end
              pss_pkg::REQ_REVERSE: begin
                if (cnt == '0) begin
                  status <= pss_pkg::ST_EMPTY;
                end else begin
                  ptr   <= '0;
                  lim   <= cnt - CW'(1);
                  state <= S_REV_LO;
                end
              end
              default: begin
                status <= pss_pkg::ST_OK;
              end
            endcase
          end
        end
        // move entries up one place, top first
        S_INS_SHIFT: begin
          if (ptr > lim) begin
            pend      <= 1'b1;
            pend_addr <= AW'(ptr);
            ptr       <= ptr - CW'(1);
          end else begin
            state <= S_INS_PUT;
          end
        end
        S_INS_PUT: begin
          cnt   <= cnt + CW'(1);
          state <= S_DONE;
        end
        S_DEL_RD: begin
          state <= S_DEL_GET;
        end
        S_DEL_GET: begin
          removed <= 32'(mem_rdata);
          state   <= S_DEL_SHIFT;
        end
        // move entries down one place, bottom first
        S_DEL_SHIFT: begin
          if (ptr + CW'(1) < cnt) begin
            pend      <= 1'b1;
            pend_addr <= AW'(ptr);
            ptr       <= ptr + CW'(1);
          end else begin
            cnt   <= cnt - CW'(1);
            state <= S_DONE;
          end
        end
        S_SRCH: begin
          if (ptr < cnt) begin
            chk     <= 1'b1;
            chk_idx <= ptr;
            ptr     <= ptr + CW'(1);
          end else if (!chk) begin
            if (req != pss_pkg::REQ_COUNT_KEY && where == '0) begin
              status <= pss_pkg::ST_NOT_FOUND;
            end
            state <= S_DONE;
          end
        end
        // swap the outer pair, then step inward
        S_REV_LO: begin
          state <= (ptr < lim) ? S_REV_HI : S_DONE;
        end
        // low word arrives here, high word is read again in the next cycle
        S_REV_HI: begin
          tmp   <= mem_rdata;
          state <= S_REV_A;
        end
        S_REV_A: begin
          state <= S_REV_B;
        end
        S_REV_B: begin
          state <= S_REV_C;
        end
        S_REV_C: begin
          ptr   <= ptr + CW'(1);
          lim   <= lim - CW'(1);
          state <= S_REV_LO;
        end
        S_DONE: begin
          if (res_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst) cnt <= CW'(DEPTH))
    else $error("entry count above depth");
  a_idle_no_write: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !mem_we)
    else $error("ram write while idle");
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> in_stall)
    else $error("not busy after accepting a word");
`endif

endmodule

// ===== rtl/core/positional_sequence_store.sv =====
// top level of the positional sequence store
// An ordered list of up to DEPTH values held in one entry ram, with insert,
// delete, find, count and reverse requests addressed by 1-based position.
// Request channel: in_valid / in_stall / in_data; a word is taken on a
// rising edge with in_valid high and in_stall low. One request is worked at
// a time; in_stall stays high from acceptance until its response is loaded.
// Response channel: out_valid / out_stall / out_data, one word per request,
// held in an output register so the block returns to idle while it waits.
// Work per request grows with the entries stored: insert and delete move
// each entry from the slot upward one place, find and count read all
// stored entries, and reverse swaps outer pairs, stepping inward.
// Refused or unused requests touch no entry and go straight to the response.
// Reset (rst, synchronous) empties the list; ram contents are not cleared.
// A stalled response holds out_data; a finished request waits for the slot.
module positional_sequence_store #(
  parameter int DEPTH = 64,
  parameter int DATA_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  pss_pkg::req_word_t in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output pss_pkg::rsp_word_t out_data
);

  localparam int AW = $clog2(DEPTH);

  logic                  res_free;
  logic                  res_valid;
  pss_pkg::rsp_word_t    res_data;
  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic [DATA_WIDTH-1:0] mem_wdata;
  logic [AW-1:0]         mem_raddr;
  logic [DATA_WIDTH-1:0] mem_rdata;

  // entry storage
  pss_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // request sequencer
  pss_ctrl #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .res_free  (res_free),
    .res_valid (res_valid),
    .res_data  (res_data),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  // output register
  assign res_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_data <= res_data;
    end
  end

endmodule
